// File: hw/rtl/ptc_pkg.sv
// ============================================================================
// ptc_pkg
// Shared types and constants of the pressure and temperature compensation
// pipeline.
// ============================================================================
`default_nettype none

package ptc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int RAW_W       = 20;
    localparam int TEMP_W      = 16;
    localparam int PRESS_W     = 32;
    localparam int DIV_BITS    = 64;
    localparam int DEN_W       = 31;

    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CALIB       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CALIB_A    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CALIB_B    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CALIB_LAST = 2'd3;

    localparam logic signed [31:0] FINE_OFFSET = 32'sd128000;
    localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
    localparam logic [63:0]        NUM_SCALE   = 64'd3125;
    localparam logic signed [35:0] TEMP_ROUND  = 36'sd128;
    localparam logic signed [63:0] COEF_BIAS   = 64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } calib_t;

    typedef struct packed {
        logic signed [31:0]       fine;
        logic signed [TEMP_W-1:0] temp_centi;
        logic [RAW_W-1:0]         raw_press;
    } temp_res_t;

    typedef struct packed {
        logic [DIV_BITS-1:0]      num_mag;
        logic [DEN_W-1:0]         den_mag;
        logic                     q_neg;
        logic                     den_zero;
        logic signed [TEMP_W-1:0] temp_centi;
    } div_req_t;

    typedef struct packed {
        logic [DIV_BITS-1:0]      quo_mag;
        logic                     q_neg;
        logic                     den_zero;
        logic signed [TEMP_W-1:0] temp_centi;
    } div_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/pressure_temperature_compensation.sv
// ============================================================================
// pressure_temperature_compensation
// Integer temperature and pressure compensation pipeline, 64-bit scheme.
// ============================================================================
// Usage: calibration words are loaded through the cfg channel (cfg_ready is
// always high) while the pipeline holds no item. A transfer on the input
// channel carries one raw temperature and one raw pressure reading; each
// transfer yields exactly one result transfer with the temperature in
// hundredths of a degree, the pressure in Q24.8 pascals and its valid flag.
// Items pass through the temperature path, the divisor and numerator
// stages, the divider (one quotient bit per stage, and it sets the depth)
// and the pressure correction, whose last stage is the output register.
// Throughput is one item per cycle unless out_stall holds the pipeline.
// Reset clears all valid bits and all calibration registers; with the
// calibration at reset the divisor is zero and press_valid reads 0.
// While out_valid is high and out_stall is asserted the whole pipeline
// holds and in_stall is raised; no item is lost or repeated.
// ============================================================================
`default_nettype none

module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [RAW_W-1:0]         raw_temp,
    input  logic [RAW_W-1:0]         raw_press,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] temp_centi,
    output logic [PRESS_W-1:0]       press_q24_8,
    output logic                     press_valid,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    logic [47:0]        temp_calib_reg;
    logic [63:0]        press_calib_a_reg;
    logic [63:0]        press_calib_b_reg;
    logic signed [15:0] press_calib_last_reg;
    calib_t             calib;
    logic               en;
    logic               temp_valid;
    temp_res_t          temp_res;
    logic               coef_valid;
    div_req_t           div_req;
    logic               div_valid;
    div_res_t           div_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg       <= '0;
            press_calib_a_reg    <= '0;
            press_calib_b_reg    <= '0;
            press_calib_last_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TEMP_CALIB:       temp_calib_reg       <= cfg_data[47:0];
                REG_PRESS_CALIB_A:    press_calib_a_reg    <= cfg_data;
                REG_PRESS_CALIB_B:    press_calib_b_reg    <= cfg_data;
                REG_PRESS_CALIB_LAST: press_calib_last_reg <= $signed(cfg_data[15:0]);
                default:              temp_calib_reg       <= temp_calib_reg;
            endcase
        end
    end

    always_comb
    begin
        calib.t1 = temp_calib_reg[15:0];
        calib.t2 = $signed(temp_calib_reg[31:16]);
        calib.t3 = $signed(temp_calib_reg[47:32]);
        calib.p1 = press_calib_a_reg[15:0];
        calib.p2 = $signed(press_calib_a_reg[31:16]);
        calib.p3 = $signed(press_calib_a_reg[47:32]);
        calib.p4 = $signed(press_calib_a_reg[63:48]);
        calib.p5 = $signed(press_calib_b_reg[15:0]);
        calib.p6 = $signed(press_calib_b_reg[31:16]);
        calib.p7 = $signed(press_calib_b_reg[47:32]);
        calib.p8 = $signed(press_calib_b_reg[63:48]);
        calib.p9 = press_calib_last_reg;
    end

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    ptc_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .raw_temp  (raw_temp),
        .raw_press (raw_press),
        .calib     (calib),
        .out_valid (temp_valid),
        .out_res   (temp_res)
    );

    ptc_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (temp_valid),
        .in_res    (temp_res),
        .calib     (calib),
        .out_valid (coef_valid),
        .out_req   (div_req)
    );

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coef_valid),
        .in_req    (div_req),
        .out_valid (div_valid),
        .out_res   (div_res)
    );

    ptc_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (div_valid),
        .in_res      (div_res),
        .calib       (calib),
        .out_valid   (out_valid),
        .temp_centi  (temp_centi),
        .press_q24_8 (press_q24_8),
        .press_valid (press_valid)
    );

    a_press_zero_when_invalid: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !press_valid |-> press_q24_8 == '0
    ) else $error("pressure not cleared on a zero divisor");

    a_no_stall_without_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall
    ) else $error("input stalled with no result waiting");

endmodule

`default_nettype wire

// File: hw/rtl/ptc_temp.sv
// ============================================================================
// ptc_temp
// Five-stage temperature path: fine temperature and saturated hundredths.
// ============================================================================
`default_nettype none

module ptc_temp
    import ptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [RAW_W-1:0] raw_temp,
    input  logic [RAW_W-1:0] raw_press,
    input  calib_t           calib,
    output logic             out_valid,
    output temp_res_t        out_res
);

    logic [4:0]               valid_reg;
    logic signed [17:0]       x_reg, x_next;
    logic signed [16:0]       d_reg, d_next;
    logic signed [33:0]       m1_reg, m1_next;
    logic signed [33:0]       dd_reg, dd_next;
    logic signed [22:0]       v1_reg, v1_next;
    logic signed [37:0]       m2_reg, m2_next;
    logic signed [31:0]       fine_reg, fine_next;
    logic [RAW_W-1:0]         rp1_reg, rp2_reg, rp3_reg, rp4_reg;
    temp_res_t                res_reg, res_next;
    logic signed [35:0]       tsum;
    logic signed [27:0]       tq;

    always_comb
    begin
        x_next  = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
        d_next  = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, calib.t1});
        m1_next = x_reg * $signed(calib.t2);
        dd_next = d_reg * d_reg;
        v1_next = $signed(m1_reg[33:11]);
        m2_next = $signed({1'b0, dd_reg[32:12]}) * $signed(calib.t3);
        fine_next = $signed({{9{v1_reg[22]}}, v1_reg})
                  + $signed({{8{m2_reg[37]}}, m2_reg[37:14]});
        tsum = $signed({{4{fine_reg[31]}}, fine_reg})
             + $signed({{2{fine_reg[31]}}, fine_reg, 2'b00}) + TEMP_ROUND;
        tq = $signed(tsum[35:8]);
        res_next.fine      = fine_reg;
        res_next.raw_press = rp4_reg;
        if ((&tq[27:15]) || !(|tq[27:15]))
        begin
            res_next.temp_centi = $signed(tq[15:0]);
        end
        else if (tq[27])
        begin
            res_next.temp_centi = 16'sh8000;
        end
        else
        begin
            res_next.temp_centi = 16'sh7FFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            d_reg    <= d_next;
            rp1_reg  <= raw_press;
            m1_reg   <= m1_next;
            dd_reg   <= dd_next;
            rp2_reg  <= rp1_reg;
            v1_reg   <= v1_next;
            m2_reg   <= m2_next;
            rp3_reg  <= rp2_reg;
            fine_reg <= fine_next;
            rp4_reg  <= rp3_reg;
            res_reg  <= res_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ptc_coef.sv
// ============================================================================
// ptc_coef
// Seven-stage pressure front end: builds the divisor and the numerator and
// hands their magnitudes and signs to the divider.
// ============================================================================
`default_nettype none

module ptc_coef
    import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  temp_res_t in_res,
    input  calib_t    calib,
    output logic      out_valid,
    output div_req_t  out_req
);

    logic [6:0]               valid_reg;
    logic signed [24:0]       a_reg, a_next;
    logic [20:0]              pp1_reg, pp2_reg, pp3_reg, pp4_reg, pp_next;
    logic signed [49:0]       aa_reg, aa_next;
    logic signed [40:0]       ap5_reg, ap5_next;
    logic signed [40:0]       ap2_reg, ap2_next;
    logic signed [63:0]       aap6_reg, aap6_next;
    logic signed [63:0]       aap3_reg, aap3_next;
    logic signed [63:0]       bpart_reg, bpart_next;
    logic signed [63:0]       ap2s_reg, ap2s_next;
    logic signed [63:0]       b_reg, b_next;
    logic signed [55:0]       s_reg, s_next;
    logic signed [63:0]       s_wide;
    logic signed [72:0]       prod_full;
    logic [63:0]              prod_reg;
    logic [63:0]              num0_reg, num0_next;
    logic [DEN_W-1:0]         den_reg;
    logic [63:0]              num_reg, num_next;
    logic signed [TEMP_W-1:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    div_req_t                 req_reg, req_next;

    always_comb
    begin
        a_next    = 25'(in_res.fine - FINE_OFFSET);
        pp_next   = PRESS_FULL - {1'b0, in_res.raw_press};
        aa_next   = a_reg * a_reg;
        ap5_next  = a_reg * $signed(calib.p5);
        ap2_next  = a_reg * $signed(calib.p2);
        aap6_next = aa_reg * $signed(calib.p6);
        aap3_next = aa_reg * $signed(calib.p3);
        bpart_next = $signed({{23{ap5_reg[40]}}, ap5_reg} << 17)
                   + $signed({{48{calib.p4[15]}}, calib.p4} << 35);
        ap2s_next = $signed({{23{ap2_reg[40]}}, ap2_reg} << 12);
        b_next    = aap6_reg + bpart_reg;
        s_wide    = (aap3_reg >>> 8) + ap2s_reg + COEF_BIAS;
        s_next    = s_wide[55:0];
        prod_full = s_reg * $signed({1'b0, calib.p1});
        num0_next = 64'({11'b0, pp4_reg, 31'b0}) - b_reg;
        num_next  = num0_reg * NUM_SCALE;
        req_next.num_mag    = num_reg[63] ? (~num_reg + 64'd1) : num_reg;
        req_next.den_mag    = den_reg[DEN_W-1] ? (~den_reg + 31'd1) : den_reg;
        req_next.q_neg      = num_reg[63] ^ den_reg[DEN_W-1];
        req_next.den_zero   = (den_reg == '0);
        req_next.temp_centi = t6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_next;
            pp1_reg   <= pp_next;
            t1_reg    <= in_res.temp_centi;
            aa_reg    <= aa_next;
            ap5_reg   <= ap5_next;
            ap2_reg   <= ap2_next;
            pp2_reg   <= pp1_reg;
            t2_reg    <= t1_reg;
            aap6_reg  <= aap6_next;
            aap3_reg  <= aap3_next;
            bpart_reg <= bpart_next;
            ap2s_reg  <= ap2s_next;
            pp3_reg   <= pp2_reg;
            t3_reg    <= t2_reg;
            b_reg     <= b_next;
            s_reg     <= s_next;
            pp4_reg   <= pp3_reg;
            t4_reg    <= t3_reg;
            prod_reg  <= prod_full[63:0];
            num0_reg  <= num0_next;
            t5_reg    <= t4_reg;
            den_reg   <= prod_reg[63:33];
            num_reg   <= num_next;
            t6_reg    <= t5_reg;
            req_reg   <= req_next;
        end
    end

    assign out_valid = valid_reg[6];
    assign out_req   = req_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ptc_div.sv
// ============================================================================
// ptc_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ============================================================================
`default_nettype none

module ptc_div
    import ptc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  div_req_t in_req,
    output logic     out_valid,
    output div_res_t out_res
);

    typedef struct packed {
        logic [DEN_W-1:0]         rem;
        logic [DIV_BITS-1:0]      nq;
        logic [DEN_W-1:0]         den;
        logic                     q_neg;
        logic                     den_zero;
        logic signed [TEMP_W-1:0] temp_centi;
    } div_stage_t;

    logic [DIV_BITS-1:0] valid_reg;
    div_stage_t          stage_reg [DIV_BITS];
    div_stage_t          head;

    always_comb
    begin
        head.rem        = '0;
        head.nq         = in_req.num_mag;
        head.den        = in_req.den_mag;
        head.q_neg      = in_req.q_neg;
        head.den_zero   = in_req.den_zero;
        head.temp_centi = in_req.temp_centi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DIV_BITS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_step
        div_stage_t   src;
        div_stage_t   step_next;
        logic [DEN_W:0] trial;
        logic         ge;

        if (k == 0)
        begin : g_first
            assign src = head;
        end
        else
        begin : g_rest
            assign src = stage_reg[k-1];
        end

        always_comb
        begin
            trial = {src.rem, src.nq[DIV_BITS-1]};
            ge    = (trial >= {1'b0, src.den});
            step_next = src;
            step_next.rem = ge ? DEN_W'(trial - {1'b0, src.den}) : trial[DEN_W-1:0];
            step_next.nq  = {src.nq[DIV_BITS-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k] <= step_next;
            end
        end
    end

    assign out_valid          = valid_reg[DIV_BITS-1];
    assign out_res.quo_mag    = stage_reg[DIV_BITS-1].nq;
    assign out_res.q_neg      = stage_reg[DIV_BITS-1].q_neg;
    assign out_res.den_zero   = stage_reg[DIV_BITS-1].den_zero;
    assign out_res.temp_centi = stage_reg[DIV_BITS-1].temp_centi;

endmodule

`default_nettype wire

// File: hw/rtl/ptc_post.sv
// ============================================================================
// ptc_post
// Six-stage pressure back end: second-order correction and Q24.8 output
// register.
// ============================================================================
`default_nettype none

module ptc_post
    import ptc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  div_res_t                 in_res,
    input  calib_t                   calib,
    output logic                     out_valid,
    output logic signed [TEMP_W-1:0] temp_centi,
    output logic [PRESS_W-1:0]       press_q24_8,
    output logic                     press_valid
);

    logic [5:0]               valid_reg;
    logic signed [63:0]       q1_reg, q2_reg, q3_reg, q_next;
    logic signed [50:0]       r13_reg;
    logic signed [66:0]       u_full;
    logic signed [79:0]       p8q_full;
    logic [63:0]              u_reg, p8q_reg;
    logic [63:0]              rx;
    logic [63:0]              pll_reg, pll_next;
    logic [31:0]              c1_reg, c1_next, c2_reg, c2_next, csum;
    logic signed [44:0]       b8_reg;
    logic [63:0]              v_reg, v_next;
    logic [63:0]              qb_reg, qb_next;
    logic [63:0]              sum_reg, sum_next;
    logic [PRESS_W-1:0]       press_next;
    logic                     dz1_reg, dz2_reg, dz3_reg, dz4_reg, dz5_reg;
    logic signed [TEMP_W-1:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic signed [TEMP_W-1:0] temp_out_reg;
    logic [PRESS_W-1:0]       press_out_reg;
    logic                     pvalid_out_reg;

    always_comb
    begin
        q_next   = in_res.q_neg ? $signed(~in_res.quo_mag + 64'd1) : $signed(in_res.quo_mag);
        u_full   = $signed(calib.p9) * $signed(q1_reg[63:13]);
        p8q_full = $signed(calib.p8) * q1_reg;
        rx       = {{13{r13_reg[50]}}, r13_reg};
        pll_next = u_reg[31:0] * rx[31:0];
        c1_next  = u_reg[63:32] * rx[31:0];
        c2_next  = u_reg[31:0] * rx[63:32];
        csum     = c1_reg + c2_reg;
        v_next   = pll_reg + {csum, 32'b0};
        qb_next  = q3_reg + {{19{b8_reg[44]}}, b8_reg};
        sum_next = qb_reg + {{25{v_reg[63]}}, v_reg[63:25]};
        press_next = sum_reg[39:8] + {{12{calib.p7[15]}}, calib.p7, 4'b0000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg         <= q_next;
            dz1_reg        <= in_res.den_zero;
            t1_reg         <= in_res.temp_centi;
            r13_reg        <= $signed(q1_reg[63:13]);
            u_reg          <= u_full[63:0];
            p8q_reg        <= p8q_full[63:0];
            q2_reg         <= q1_reg;
            dz2_reg        <= dz1_reg;
            t2_reg         <= t1_reg;
            pll_reg        <= pll_next;
            c1_reg         <= c1_next;
            c2_reg         <= c2_next;
            b8_reg         <= $signed(p8q_reg[63:19]);
            q3_reg         <= q2_reg;
            dz3_reg        <= dz2_reg;
            t3_reg         <= t2_reg;
            v_reg          <= v_next;
            qb_reg         <= qb_next;
            dz4_reg        <= dz3_reg;
            t4_reg         <= t3_reg;
            sum_reg        <= sum_next;
            dz5_reg        <= dz4_reg;
            t5_reg         <= t4_reg;
            temp_out_reg   <= t5_reg;
            press_out_reg  <= dz5_reg ? '0 : press_next;
            pvalid_out_reg <= !dz5_reg;
        end
    end

    assign out_valid   = valid_reg[5];
    assign temp_centi  = temp_out_reg;
    assign press_q24_8 = press_out_reg;
    assign press_valid = pvalid_out_reg;

endmodule

`default_nettype wire
